### design/prmu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prmu_pkg
// Shared widths, register codes and reset values for the Potts ring
// Metropolis update block.
// ----------------------------------------------------------------------------
package prmu_pkg;

	localparam int SITE_W      = 7;
	localparam int STATE_W     = 4;
	localparam int RAND_W      = 32;
	localparam int THRESH_W    = 33;
	localparam int DELTA_W     = 3;
	localparam int ENERGY_W    = 8;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int THRESH_N    = 5;

	// register index; also the threshold slot for energy change + 2
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DELTA_MINUS2 = 3'd0,
		REG_DELTA_MINUS1 = 3'd1,
		REG_DELTA_ZERO   = 3'd2,
		REG_DELTA_PLUS1  = 3'd3,
		REG_DELTA_PLUS2  = 3'd4
	} reg_idx_t;

	localparam logic [THRESH_W-1:0] THRESH_RST_MINUS2 = 33'd4294967296;
	localparam logic [THRESH_W-1:0] THRESH_RST_MINUS1 = 33'd4294967296;
	localparam logic [THRESH_W-1:0] THRESH_RST_ZERO   = 33'd4294967296;
	localparam logic [THRESH_W-1:0] THRESH_RST_PLUS1  = 33'd1580030169;
	localparam logic [THRESH_W-1:0] THRESH_RST_PLUS2  = 33'd581260615;

endpackage

### design/prmu_spin_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prmu_spin_ram
// One copy of the spin store: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module prmu_spin_ram #(
	parameter int DEPTH = 128,
	parameter int AW    = 7,
	parameter int DW    = 4
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### design/potts_ring_metropolis_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// potts_ring_metropolis_update
// Metropolis update of a Potts spin ring with running energy. Each
// transaction proposes a spin value for one site; the block works out the
// energy change from both ring neighbors, tests it against a threshold and
// writes the site on acceptance.
// ----------------------------------------------------------------------------
// channel  dir  handshake         payload
// s_       in   s_tvalid/s_tready tuser: func; tdata: site, new_state, random_frac
// m_       out  m_tvalid/m_tready tuser: accepted; tdata: energy_delta, energy_now
// cfg_     in   cfg_we            cfg_index, cfg_wdata (threshold registers)
//
// one transaction per cycle sustained while the output is not stalled; the spin read
// goes into stage 1, then the decision and write into the output register.
// the site/neighbor reads come from three copies of the spin store; a write
// made at the edge of a read is forwarded into stage 1.
// reset: spins read as zero through per-site valid bits, energy is -SITES,
// thresholds take their defaults. no clearing pass.
// a stalled output holds stage 1; input keeps flowing while stage 1 moves.
// ----------------------------------------------------------------------------
module potts_ring_metropolis_update #(
	parameter int SITES      = 128,
	parameter int MAX_STATES = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// [6:0] site, [10:7] new_state, [42:11] random_frac, rest zero
	input  logic [prmu_pkg::IN_TDATA_W-1:0]      s_tdata,
	// [0] func
	input  logic                                 s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [2:0] energy_delta, [10:3] energy_now, rest zero
	output logic [prmu_pkg::OUT_TDATA_W-1:0]     m_tdata,
	// [0] accepted
	output logic                                 m_tuser,
	input  logic                                 cfg_we,
	input  logic [prmu_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [prmu_pkg::THRESH_W-1:0]        cfg_wdata
);

	import prmu_pkg::*;

	localparam int AW  = (SITES > 1) ? $clog2(SITES) : 1;
	localparam int SPW = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
	localparam int EW  = $clog2(SITES + 1) + 1;

	// input field split
	logic [SITE_W-1:0]  in_site;
	logic [STATE_W-1:0] in_nv;
	logic [RAND_W-1:0]  in_rnd;
	logic [AW-1:0]      in_addr;
	logic [AW-1:0]      in_right;
	logic [AW-1:0]      in_left;
	logic               in_range;
	logic               in_fire;

	assign in_site  = s_tdata[SITE_W-1:0];
	assign in_nv    = s_tdata[SITE_W+STATE_W-1:SITE_W];
	assign in_rnd   = s_tdata[SITE_W+STATE_W+RAND_W-1:SITE_W+STATE_W];
	assign in_addr  = AW'(in_site);
	assign in_right = (in_addr == AW'(SITES - 1)) ? '0 : in_addr + AW'(1);
	assign in_left  = (in_addr == '0) ? AW'(SITES - 1) : in_addr - AW'(1);
	assign in_range = (32'(in_site) < 32'(SITES)) && (32'(in_nv) < 32'(MAX_STATES));
	assign in_fire  = s_tvalid && s_tready;

	// stage 1
	logic               vld_s1;
	logic               func_s1;
	logic               range_s1;
	logic [AW-1:0]      addr_s1;
	logic [AW-1:0]      right_s1;
	logic [AW-1:0]      left_s1;
	logic [STATE_W-1:0] nv_s1;
	logic [RAND_W-1:0]  rnd_s1;
	logic               ov_vld_s1;
	logic               rv_vld_s1;
	logic               lv_vld_s1;
	logic [SPW-1:0]     ov_ram;
	logic [SPW-1:0]     rv_ram;
	logic [SPW-1:0]     lv_ram;

	// last spin write, for forwarding into a read made at the same edge
	logic               wr_vld_q;
	logic [AW-1:0]      wr_addr_q;
	logic [SPW-1:0]     wr_data_q;

	logic [SITES-1:0]   spin_vld_q;
	logic signed [EW-1:0] energy_q;
	logic [THRESH_W-1:0]  thresh_q [THRESH_N];

	logic               out_vld_q;
	logic               out_acc_q;
	logic signed [DELTA_W-1:0]  out_delta_q;
	logic signed [ENERGY_W-1:0] out_energy_q;

	logic               s1_fire;
	logic [SPW-1:0]     ov;
	logic [SPW-1:0]     rv;
	logic [SPW-1:0]     lv;
	logic [SPW-1:0]     nv;
	logic signed [DELTA_W-1:0] delta_raw;
	logic signed [DELTA_W-1:0] delta;
	logic [CFG_IDX_W-1:0] thr_idx;
	logic [THRESH_W-1:0]  thr;
	logic               accept;
	logic signed [EW-1:0] energy_next;

	assign s1_fire  = vld_s1 && (!out_vld_q || m_tready);
	assign s_tready = !vld_s1 || s1_fire;

	prmu_spin_ram #(.DEPTH(SITES), .AW(AW), .DW(SPW)) u_ram_site (
		.clk   (clk),
		.we    (s1_fire && accept),
		.waddr (addr_s1),
		.wdata (nv),
		.re    (in_fire),
		.raddr (in_addr),
		.rdata (ov_ram)
	);

	prmu_spin_ram #(.DEPTH(SITES), .AW(AW), .DW(SPW)) u_ram_right (
		.clk   (clk),
		.we    (s1_fire && accept),
		.waddr (addr_s1),
		.wdata (nv),
		.re    (in_fire),
		.raddr (in_right),
		.rdata (rv_ram)
	);

	prmu_spin_ram #(.DEPTH(SITES), .AW(AW), .DW(SPW)) u_ram_left (
		.clk   (clk),
		.we    (s1_fire && accept),
		.waddr (addr_s1),
		.wdata (nv),
		.re    (in_fire),
		.raddr (in_left),
		.rdata (lv_ram)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			func_s1   <= s_tuser;
			range_s1  <= in_range;
			addr_s1   <= in_addr;
			right_s1  <= in_right;
			left_s1   <= in_left;
			nv_s1     <= in_nv;
			rnd_s1    <= in_rnd;
			ov_vld_s1 <= spin_vld_q[in_addr];
			rv_vld_s1 <= spin_vld_q[in_right];
			lv_vld_s1 <= spin_vld_q[in_left];
		end
	end

	// spin values seen by stage 1, with the forwarded write on top
	always_comb begin
		ov = ov_vld_s1 ? ov_ram : '0;
		rv = rv_vld_s1 ? rv_ram : '0;
		lv = lv_vld_s1 ? lv_ram : '0;
		if (wr_vld_q && wr_addr_q == addr_s1) begin
			ov = wr_data_q;
		end
		if (wr_vld_q && wr_addr_q == right_s1) begin
			rv = wr_data_q;
		end
		if (wr_vld_q && wr_addr_q == left_s1) begin
			lv = wr_data_q;
		end
	end

	assign nv = SPW'(nv_s1);

	assign delta_raw = $signed({2'b00, ov == rv}) + $signed({2'b00, ov == lv})
		- $signed({2'b00, nv == rv}) - $signed({2'b00, nv == lv});
	assign delta     = range_s1 ? delta_raw : '0;
	assign thr_idx   = CFG_IDX_W'(delta + 3'sd2);

	always_comb begin
		case (thr_idx)
			REG_DELTA_MINUS2: thr = thresh_q[REG_DELTA_MINUS2];
			REG_DELTA_MINUS1: thr = thresh_q[REG_DELTA_MINUS1];
			REG_DELTA_ZERO:   thr = thresh_q[REG_DELTA_ZERO];
			REG_DELTA_PLUS1:  thr = thresh_q[REG_DELTA_PLUS1];
			REG_DELTA_PLUS2:  thr = thresh_q[REG_DELTA_PLUS2];
			default:          thr = thresh_q[REG_DELTA_ZERO];
		endcase
	end

	assign accept      = range_s1 && (func_s1 || ({1'b0, rnd_s1} < thr));
	assign energy_next = accept ? energy_q + EW'(delta) : energy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spin_vld_q <= '0;
			energy_q   <= -EW'(SITES);
			wr_vld_q   <= 1'b0;
		end else if (s1_fire) begin
			energy_q <= energy_next;
			wr_vld_q <= accept;
			if (accept) begin
				spin_vld_q[addr_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			wr_addr_q <= addr_s1;
			wr_data_q <= nv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q[REG_DELTA_MINUS2] <= THRESH_RST_MINUS2;
			thresh_q[REG_DELTA_MINUS1] <= THRESH_RST_MINUS1;
			thresh_q[REG_DELTA_ZERO]   <= THRESH_RST_ZERO;
			thresh_q[REG_DELTA_PLUS1]  <= THRESH_RST_PLUS1;
			thresh_q[REG_DELTA_PLUS2]  <= THRESH_RST_PLUS2;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DELTA_MINUS2: thresh_q[REG_DELTA_MINUS2] <= cfg_wdata;
				REG_DELTA_MINUS1: thresh_q[REG_DELTA_MINUS1] <= cfg_wdata;
				REG_DELTA_ZERO:   thresh_q[REG_DELTA_ZERO]   <= cfg_wdata;
				REG_DELTA_PLUS1:  thresh_q[REG_DELTA_PLUS1]  <= cfg_wdata;
				REG_DELTA_PLUS2:  thresh_q[REG_DELTA_PLUS2]  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_fire) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			out_acc_q    <= accept;
			out_delta_q  <= delta;
			out_energy_q <= ENERGY_W'(energy_next);
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_acc_q;
	assign m_tdata  = {{(OUT_TDATA_W - DELTA_W - ENERGY_W){1'b0}}, out_energy_q, out_delta_q};

endmodule
